// ===== hw/rtl/sacta_pkg.sv =====
package sacta_pkg;

  localparam int MAX_WAYS = 8;
  localparam int MAX_SETS = 1024;
  localparam int unsigned SET_FW = 10;   // widest set index (index_bits <= 10)
  localparam int unsigned OFFSET_LIMIT = 12;
  localparam int unsigned INDEX_LIMIT = 10;
  localparam logic [31:0] LRU_START_BOUND = 32'd4294836225;

  localparam logic [2:0] ACT_LOOKUP    = 3'd0;
  localparam logic [2:0] ACT_FILL      = 3'd1;
  localparam logic [2:0] ACT_SET_DIRTY = 3'd2;
  localparam logic [2:0] ACT_WB_UPDATE = 3'd3;
  localparam logic [2:0] ACT_SET_VALID = 3'd4;
  localparam logic [2:0] ACT_GET_DIRTY = 3'd5;

  typedef struct packed {
    logic [2:0]        action;
    logic [SET_FW-1:0] set_idx;
    logic [31:0]       tag;
    logic [31:0]       tstamp;
    logic              bit_value;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  way;
    logic        dirty;
    logic        victim_valid;
    logic [31:0] victim_address;
  } res_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] stamp;
    logic        valid;
    logic        dirty;
  } line_t;

endpackage

// ===== hw/rtl/sacta_ram.sv =====
module sacta_ram #(
  parameter int W = 66,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [W-1:0]                     wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [W-1:0]                     rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/sacta_fifo.sv =====
module sacta_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  logic [W-1:0] slot_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) slot_r[wp_r] <= din;
  end
endmodule

// ===== hw/rtl/sacta_front.sv =====
module sacta_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          ob,
  input  logic [3:0]          ib,
  input  logic                push,
  input  logic [2:0]          action,
  input  logic [31:0]         address,
  input  logic [31:0]         tstamp,
  input  logic                bit_value,
  output logic                full,
  input  logic                pop,
  output sacta_pkg::cmd_t     head,
  output logic                empty
);
  import sacta_pkg::*;

  cmd_t        cmd;
  logic [31:0] shifted;
  logic [9:0]  raw_set;
  logic [5:0]  tag_sh;

  always_comb begin
    shifted = address >> ob;
    raw_set = shifted[9:0] & ((10'd1 << ib) - 10'd1);
    tag_sh  = {2'b00, ob} + {2'b00, ib};
    cmd.action     = action;
    // The array holds every set that a ten-bit index can name, so no wrap is needed.
    cmd.set_idx    = raw_set;
    cmd.tag        = address >> tag_sh;
    cmd.tstamp     = tstamp;
    cmd.bit_value  = bit_value;
  end

  sacta_fifo #(.W($bits(cmd_t))) u_q (
    .clk, .rst_n, .push, .din(cmd), .full, .pop, .dout(head), .empty
  );
endmodule

// ===== hw/rtl/sacta_back.sv =====
module sacta_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [3:0]      ob,
  input  logic [3:0]      ib,
  input  logic [4:0]      nw,
  input  sacta_pkg::cmd_t head,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  output logic            res_push,
  output sacta_pkg::res_t res,
  input  logic            res_full
);
  import sacta_pkg::*;

  localparam int AW = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);
  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0]    st_r, st_nxt;
  logic [AW-1:0] clr_r;
  cmd_t          cur_r;
  line_t         rd [MAX_WAYS];
  line_t         wr_line;
  logic          wr_en;
  logic [4:0]    wr_way;
  logic [AW-1:0] raddr;
  logic [31:0]   best;
  logic [4:0]    victim, match_w;
  logic          found, need_valid;

  assign raddr   = AW'(head.set_idx);
  assign cmd_pop = (st_r == ST_IDLE) && !cmd_empty && !res_full;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLR:  if (clr_r == AW'(MAX_SETS - 1)) st_nxt = ST_IDLE;
      ST_IDLE: if (cmd_pop) st_nxt = ST_EXEC;
      ST_EXEC: st_nxt = ST_IDLE;
      default: st_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLR;
      clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLR) clr_r <= clr_r + AW'(1);
    end
    if (cmd_pop) cur_r <= head;
  end

  always_comb begin
    best = LRU_START_BOUND;
    victim = 5'd0;
    found = 1'b0;
    match_w = 5'd0;
    need_valid = !(cur_r.action == ACT_WB_UPDATE || cur_r.action == ACT_SET_VALID);
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (5'(w) < nw) begin
        if (rd[w].stamp < best) begin
          best = rd[w].stamp;
          victim = 5'(w);
        end
        if (!found && rd[w].tag == cur_r.tag && (rd[w].valid || !need_valid)) begin
          found = 1'b1;
          match_w = 5'(w);
        end
      end
    end
  end

  always_comb begin
    line_t sel;
    logic  is_fill, known;
    is_fill = (cur_r.action == ACT_FILL);
    known   = (cur_r.action <= ACT_GET_DIRTY);
    wr_way  = is_fill ? victim : match_w;
    sel     = rd[wr_way[$clog2(MAX_WAYS > 1 ? MAX_WAYS : 2)-1:0]];
    wr_line = sel;
    wr_en   = 1'b0;
    res     = '0;
    if (is_fill) begin
      wr_en   = 1'b1;
      wr_line.tag   = cur_r.tag;
      wr_line.stamp = cur_r.tstamp;
      wr_line.valid = 1'b1;
      res.way   = wr_way[2:0];
      res.dirty = sel.dirty;
      res.victim_valid   = sel.valid;
      res.victim_address = ((sel.tag << ib) + 32'(cur_r.set_idx)) << ob;
    end else if (known && found) begin
      res.hit = 1'b1;
      res.way = wr_way[2:0];
      case (cur_r.action)
        ACT_LOOKUP: begin
          wr_en = 1'b1;
          wr_line.stamp = cur_r.tstamp;
        end
        ACT_SET_DIRTY: begin
          wr_en = 1'b1;
          wr_line.dirty = cur_r.bit_value;
        end
        ACT_WB_UPDATE: begin
          wr_en = 1'b1;
          wr_line.stamp = cur_r.tstamp;
          wr_line.dirty = 1'b1;
        end
        ACT_SET_VALID: begin
          wr_en = 1'b1;
          wr_line.valid = cur_r.bit_value;
        end
        default: wr_en = 1'b0;
      endcase
      res.dirty = wr_line.dirty;
    end
  end

  assign res_push = (st_r == ST_EXEC);

  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_way
    logic we;
    assign we = (st_r == ST_CLR) || (res_push && wr_en && wr_way == 5'(g));
    sacta_ram #(.W($bits(line_t)), .DEPTH(MAX_SETS)) u_ram (
      .clk,
      .we,
      .waddr((st_r == ST_CLR) ? clr_r : AW'(cur_r.set_idx)),
      .wdata((st_r == ST_CLR) ? '0 : wr_line),
      .raddr,
      .rdata(rd[g])
    );
  end
endmodule

// ===== hw/rtl/set_assoc_cache_tag_array.sv =====
// Channel  Direction  Ports                                          Handshake
// in       request    in_action in_address in_tstamp in_bit_value    push / full
// out      result     out_hit out_way out_dirty out_victim_valid
//                     out_victim_address                            pop / empty
// cfg      write      cfg_we cfg_index cfg_data                     no wait
//
// In the back end a request is first read in the idle state, all ways of the
// set from the per-way RAMs; the execute state then picks the way, writes the line and queues the result.
// After reset a clearing pass zeroes every set before requests run.
// Two-entry queues on the request and result sides let each side stall on its own.
module set_assoc_cache_tag_array (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_address,
  input  logic [31:0] in_tstamp,
  input  logic        in_bit_value,
  output logic        empty,
  input  logic        pop,
  output logic        out_hit,
  output logic [2:0]  out_way,
  output logic        out_dirty,
  output logic        out_victim_valid,
  output logic [31:0] out_victim_address,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import sacta_pkg::*;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_INDEX  = 2'd1;
  localparam logic [1:0] REG_WAYS   = 2'd2;

  logic [3:0] offset_r, index_r, ways_r;
  logic [3:0] ob, ib;
  logic [4:0] nw;
  cmd_t       head;
  logic       cmd_empty, cmd_pop, res_push, res_full;
  res_t       res, res_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 4'd6;
      index_r  <= 4'd6;
      ways_r   <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET: offset_r <= cfg_data;
        REG_INDEX:  index_r  <= cfg_data;
        REG_WAYS:   ways_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    ob = (offset_r > 4'(OFFSET_LIMIT)) ? 4'(OFFSET_LIMIT) : offset_r;
    ib = (index_r > 4'(INDEX_LIMIT)) ? 4'(INDEX_LIMIT) : index_r;
    if (ways_r == 4'd0) nw = 5'd1;
    else if ({1'b0, ways_r} > 5'(MAX_WAYS)) nw = 5'(MAX_WAYS);
    else nw = {1'b0, ways_r};
  end

  sacta_front u_front (
    .clk, .rst_n, .ob, .ib,
    .push, .action(in_action), .address(in_address),
    .tstamp(in_tstamp), .bit_value(in_bit_value),
    .full, .pop(cmd_pop), .head, .empty(cmd_empty)
  );

  sacta_back u_back (
    .clk, .rst_n, .ob, .ib, .nw, .head, .cmd_empty, .cmd_pop,
    .res_push, .res, .res_full
  );

  sacta_fifo #(.W($bits(res_t))) u_res_q (
    .clk, .rst_n, .push(res_push), .din(res), .full(res_full),
    .pop, .dout(res_head), .empty
  );

  assign out_hit            = res_head.hit;
  assign out_way            = res_head.way;
  assign out_dirty          = res_head.dirty;
  assign out_victim_valid   = res_head.victim_valid;
  assign out_victim_address = res_head.victim_address;
endmodule

// ===== tb/tb_set_assoc_cache_tag_array.sv =====
`timescale 1ns / 100ps

module tb_set_assoc_cache_tag_array;
  import sacta_pkg::*;

  localparam int NWAYS = 8;
  localparam int NSETS = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS_USED = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [2:0] ACT_RESERVED = 3'd6;
  localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

  typedef struct {
    logic [2:0]  action;
    logic [31:0] address;
    logic [31:0] tstamp;
    logic        bit_value;
  } request_t;

  typedef struct {
    request_t req;
    logic     chk;
    res_t     res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [2:0] in_action = '0;
  logic [31:0] in_address = '0;
  logic [31:0] in_tstamp = '0;
  logic in_bit_value = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic out_hit;
  logic [2:0] out_way;
  logic out_dirty;
  logic out_victim_valid;
  logic [31:0] out_victim_address;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  logic [31:0] tag_mem [NWAYS*NSETS];
  logic        valid_mem [NWAYS*NSETS];
  logic        dirty_mem [NWAYS*NSETS];
  logic [31:0] stamp_mem [NWAYS*NSETS];
  logic [3:0]  reg_offset_bits, reg_index_bits, reg_ways_used;

  res_t expected_q[$];
  int   errors = 0;
  int   idle_cycles = 0;
  bit   long_hold = 1'b0;
  bit   sender_done = 1'b0;
  int   results_seen = 0;

  always #5 clk = ~clk;

  set_assoc_cache_tag_array i_dut (.*);

  function automatic res_t cache_predict(request_t r);
    res_t o;
    int ob, ib, nw, set_n, s, victim;
    logic [31:0] tag, best;
    bit need_valid;
    o = '0;
    ob = (reg_offset_bits > 12) ? 12 : reg_offset_bits;
    ib = (reg_index_bits > 10) ? 10 : reg_index_bits;
    nw = (reg_ways_used == 0) ? 1 : (reg_ways_used > NWAYS) ? NWAYS : reg_ways_used;
    set_n = ((r.address >> ob) & ((32'd1 << ib) - 1)) % NSETS;
    tag = r.address >> (ob + ib);
    if (r.action == ACT_FILL) begin
      best = LRU_START_BOUND;
      victim = 0;
      for (int w = 0; w < nw; w++) begin
        s = w * NSETS + set_n;
        if (stamp_mem[s] < best) begin
          best = stamp_mem[s];
          victim = w;
        end
      end
      s = victim * NSETS + set_n;
      o.way = 3'(victim);
      o.dirty = dirty_mem[s];
      o.victim_valid = valid_mem[s];
      o.victim_address = ((tag_mem[s] << ib) + set_n) << ob;
      tag_mem[s] = tag;
      stamp_mem[s] = r.tstamp;
      valid_mem[s] = 1'b1;
    end else if (r.action <= ACT_GET_DIRTY) begin
      need_valid = (r.action != ACT_WB_UPDATE) && (r.action != ACT_SET_VALID);
      for (int w = 0; w < nw; w++) begin
        s = w * NSETS + set_n;
        if (tag_mem[s] == tag && (!need_valid || valid_mem[s])) begin
          o.hit = 1'b1;
          o.way = 3'(w);
          case (r.action)
            ACT_LOOKUP: stamp_mem[s] = r.tstamp;
            ACT_SET_DIRTY: dirty_mem[s] = r.bit_value;
            ACT_WB_UPDATE: begin
              stamp_mem[s] = r.tstamp;
              dirty_mem[s] = 1'b1;
            end
            ACT_SET_VALID: valid_mem[s] = r.bit_value;
            default: ;
          endcase
          o.dirty = dirty_mem[s];
          break;
        end
      end
    end
    return o;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OFFSET_BITS: reg_offset_bits = val;
      REG_INDEX_BITS: reg_index_bits = val;
      REG_WAYS_USED: reg_ways_used = val;
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Holds push high until the request is taken; push stays up between
  // back-to-back requests, so it is only lowered on a real gap.
  task automatic send_request(request_t r, int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_action <= r.action;
    in_address <= r.address;
    in_tstamp <= r.tstamp;
    in_bit_value <= r.bit_value;
    do @(posedge clk); while (full);
    expected_q.push_back(cache_predict(r));
  endtask

  function automatic request_t random_request(int tag_span, int stamp_span);
    request_t r;
    int ob, ib;
    ob = (reg_offset_bits > 12) ? 12 : reg_offset_bits;
    ib = (reg_index_bits > 10) ? 10 : reg_index_bits;
    r.action = ($urandom_range(0, 39) == 0)
               ? 3'($urandom_range(ACT_RESERVED, ACT_RESERVED_HI))
               : 3'($urandom_range(ACT_LOOKUP, ACT_GET_DIRTY));
    if ($urandom_range(0, 9) == 0) begin
      r.address = $urandom;
    end else begin
      // Few tags and sets, so that requests hit lines that earlier fills wrote.
      r.address = ((32'($urandom_range(0, tag_span)) << ib) | 32'($urandom_range(0, 3)))
                  << ob;
      r.address |= $urandom & ((32'd1 << ob) - 1);
    end
    r.tstamp = ($urandom_range(0, 19) == 0) ? $urandom
                                            : 32'($urandom_range(0, stamp_span));
    r.bit_value = 1'($urandom_range(0, 1));
    return r;
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    request_t r;
    int n;
    dir_row_t d;
    reg_offset_bits = 4'd6;
    reg_index_bits = 4'd6;
    reg_ways_used = 4'd4;
    for (int i = 0; i < NWAYS * NSETS; i++) begin
      tag_mem[i] = '0;
      valid_mem[i] = 1'b0;
      dirty_mem[i] = 1'b0;
      stamp_mem[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: the first rows hold values visible after reset.
    dir_rows = '{
      '{'{ACT_LOOKUP, 32'h0000_0000, 32'd5, 1'b0}, 1'b1, '0},
      '{'{ACT_GET_DIRTY, 32'h0000_0000, 32'd0, 1'b0}, 1'b1, '0},
      '{'{ACT_WB_UPDATE, 32'h0000_0000, 32'd9, 1'b0}, 1'b1,
        '{1'b1, 3'd0, 1'b1, 1'b0, 32'd0}},
      '{'{ACT_SET_VALID, 32'h0000_1000, 32'd0, 1'b1}, 1'b1, '0},
      '{'{ACT_FILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
      '{'{ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1}, 1'b0, '0},
      '{'{ACT_FILL, 32'hFFFF_FFC0, 32'd0, 1'b1}, 1'b0, '0},
      '{'{ACT_SET_DIRTY, 32'hFFFF_FFC0, 32'd0, 1'b1}, 1'b0, '0},
      '{'{ACT_GET_DIRTY, 32'hFFFF_FFC0, 32'd0, 1'b0}, 1'b0, '0},
      '{'{ACT_SET_DIRTY, 32'hFFFF_FFC0, 32'd0, 1'b0}, 1'b0, '0},
      '{'{ACT_FILL, 32'h1234_5678, 32'd100, 1'b0}, 1'b0, '0},
      '{'{ACT_FILL, 32'h0000_0040, 32'd3, 1'b0}, 1'b0, '0},
      '{'{ACT_FILL, 32'h0000_0000, 32'd1, 1'b0}, 1'b0, '0},
      '{'{ACT_SET_VALID, 32'h0000_0000, 32'd0, 1'b0}, 1'b0, '0},
      '{'{ACT_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1, '0},
      '{'{ACT_RESERVED_HI, 32'h0000_0000, 32'd0, 1'b1}, 1'b1, '0}
    };
    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      if (d.chk) begin
        // Replace the predicted value with the one typed in the row.
        send_request(d.req, $urandom_range(0, 3));
        expected_q[$] = d.res;
      end else begin
        send_request(d.req, $urandom_range(0, 3));
      end
    end
    push <= 1'b0;
    drain_results();

    // Register sweep, extremes included; each phase starts idle.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_OFFSET_BITS, 4'd0); write_reg(REG_INDEX_BITS, 4'd0);
                 write_reg(REG_WAYS_USED, 4'd1); end
        1: begin write_reg(REG_OFFSET_BITS, 4'd12); write_reg(REG_INDEX_BITS, 4'd10);
                 write_reg(REG_WAYS_USED, 4'd8); end
        2: begin write_reg(REG_OFFSET_BITS, 4'd15); write_reg(REG_INDEX_BITS, 4'd15);
                 write_reg(REG_WAYS_USED, 4'd0); end
        3: begin write_reg(REG_WAYS_USED, 4'd15); write_reg(REG_UNUSED, 4'd9);
                 write_reg(REG_OFFSET_BITS, 4'd2); write_reg(REG_INDEX_BITS, 4'd1); end
        default: begin
          write_reg(REG_OFFSET_BITS, 4'($urandom_range(0, 15)));
          write_reg(REG_INDEX_BITS, 4'($urandom_range(0, 15)));
          write_reg(REG_WAYS_USED, 4'($urandom_range(0, 15)));
        end
      endcase
      for (int k = 0; k < 135; k++) begin
        r = random_request(7, (ph % 2) ? 40 : 1000);
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (ph == 1 && k == 40) long_hold = 1'b1;
        send_request(r, n);
        if (ph == 5 && k == 60) begin
          push <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      push <= 1'b0;
      drain_results();
    end
    sender_done = 1'b1;
  end

  // Result side: random stalls, one long hold-off while requests keep coming.
  initial begin
    int n;
    forever begin
      if (long_hold) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit: expected %0h actual %0h", e.hit, out_hit); errors++;
        end
        if (out_way !== e.way) begin
          $error("way: expected %0h actual %0h", e.way, out_way); errors++;
        end
        if (out_dirty !== e.dirty) begin
          $error("dirty: expected %0h actual %0h", e.dirty, out_dirty); errors++;
        end
        if (out_victim_valid !== e.victim_valid) begin
          $error("victim_valid: expected %0h actual %0h", e.victim_valid,
                 out_victim_valid);
          errors++;
        end
        if (out_victim_address !== e.victim_address) begin
          $error("victim_address: expected %0h actual %0h", e.victim_address,
                 out_victim_address);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles = 0;
      else idle_cycles++;
      if (sender_done && expected_q.size() == 0) begin
        repeat (20) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
